[hw/rtl/ace_pkg.sv]
// Shared types and state encodings for the arithmetic encoder.
package ace_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_NARROW,
    ST_RENORM,
    ST_FINAL
  } ace_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input beat, start divisions
    logic div_step;    // one restoring-division step
    logic narrow;      // apply the new interval
    logic renorm;      // one renormalization step
    logic flush;       // build flush result and reset state
    logic marker;      // build marker result
    logic mark_last;   // set last_of_symbol on the held result
  } ace_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic renorm_emit;  // this renorm step emits a bit
    logic renorm_stop;  // no rule applies
    logic renorm_limit; // step budget used up
    logic eom;
  } ace_sts_t;

endpackage

[hw/rtl/arith_coder_encode.sv]
// Top level of the carry-free integer arithmetic encoder.
//
//   channel | ports                                          | dir
//   in      | in_valid in_stall in_cum_low in_cum_high       | sink
//           | in_total in_end_of_message                     |
//   out     | out_valid out_stall out_has_bit out_out_bit    | source
//           | out_follow_count out_last_of_symbol            |
//           | out_stream_done                                |
//
// One symbol passes through accept, the bit-serial divider (both quotients
// in parallel), narrowing, one renorm step after another plus a check that
// sees the loop end, the final state, and a release of each emitted bit past
// the first; an ending symbol that emitted bits also releases its last bit
// before the flush beat is built.
// Reset is synchronous active low; interval low=0, high=all ones.
// Each result beat stays in the output register until taken; out_stall
// freezes the sequencer only when a new beat has to be written.
// An emitted bit stays hidden in the result register until the next bit
// or the end of the symbol shows whether it carries last_of_symbol.
module arith_coder_encode import ace_pkg::*; #(
  parameter int PRECISION  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COUNT_BITS-1:0] in_cum_low,
  input  logic [COUNT_BITS-1:0] in_cum_high,
  input  logic [COUNT_BITS-1:0] in_total,
  input  logic                  in_end_of_message,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_has_bit,
  output logic                  out_out_bit,
  output logic [31:0]           out_follow_count,
  output logic                  out_last_of_symbol,
  output logic                  out_stream_done
);

  ace_cmd_t cmd;
  ace_sts_t sts;

  ace_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ace_datapath #(
    .PRECISION  (PRECISION),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_cum_low        (in_cum_low),
    .in_cum_high       (in_cum_high),
    .in_total          (in_total),
    .in_end_of_message (in_end_of_message),
    .res_has_bit       (out_has_bit),
    .res_bit           (out_out_bit),
    .res_follow        (out_follow_count),
    .res_last          (out_last_of_symbol),
    .res_done          (out_stream_done)
  );

`ifndef ASSERT_OFF
  // a flush beat always ends its symbol and carries a bit
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_last_of_symbol && out_has_bit)
    else $error("flush beat malformed");
  // a marker beat carries no follow bits
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_bit |-> out_follow_count == 32'd0)
    else $error("marker with follow count");
  // a held result is never overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_follow_count) && $stable(out_out_bit))
    else $error("held beat changed");
`endif

endmodule

[hw/rtl/ace_datapath.sv]
// Interval registers, serial divider and renormalization step.
module ace_datapath import ace_pkg::*; #(
  parameter int PRECISION  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ace_cmd_t              cmd,
  output ace_sts_t              sts,
  input  logic [COUNT_BITS-1:0] in_cum_low,
  input  logic [COUNT_BITS-1:0] in_cum_high,
  input  logic [COUNT_BITS-1:0] in_total,
  input  logic                  in_end_of_message,
  output logic                  res_has_bit,
  output logic                  res_bit,
  output logic [31:0]           res_follow,
  output logic                  res_last,
  output logic                  res_done
);

  localparam int P  = PRECISION;
  localparam int CB = COUNT_BITS;
  localparam int PW = P + CB;      // width of range*count
  localparam int IW = $clog2(PW + 1);
  localparam int RW = $clog2(P + 1);

  localparam logic [P-1:0] HALF   = {1'b1, {(P-1){1'b0}}};
  localparam logic [P-1:0] QUART  = {2'b01, {(P-2){1'b0}}};
  localparam logic [P-1:0] THREEQ = {2'b11, {(P-2){1'b0}}};

  logic [P-1:0]  low_r, high_r, low_nxt, high_nxt;
  logic [31:0]   pend_r, pend_nxt;
  logic [CB-1:0] t_r;
  logic          eom_r, valid_r;
  logic [PW-1:0] nh_r, nl_r;       // dividends, become quotients
  logic [CB:0]   rh_r, rl_r;       // partial remainders
  logic [IW-1:0] dcnt_r;
  logic [RW-1:0] rcnt_r;
  logic          has_r, bit_r, last_r, done_r;
  logic [31:0]   fol_r;

  // effective high: hi < lo collapses to lo
  logic [P-1:0] hi_eff;
  logic [P:0]   range_w;
  assign hi_eff  = (high_r < low_r) ? low_r : high_r;
  assign range_w = {1'b0, hi_eff} - {1'b0, low_r} + {{P{1'b0}}, 1'b1};

  // one restoring step for each quotient
  logic [CB+1:0] th, tl;
  assign th = {rh_r, nh_r[PW-1]} - {2'b0, t_r};
  assign tl = {rl_r, nl_r[PW-1]} - {2'b0, t_r};

  logic emit0, emit1, quart;
  assign emit0 = high_r < HALF;
  assign emit1 = !emit0 && (low_r >= HALF);
  assign quart = !emit0 && !emit1 && (low_r >= QUART) && (high_r < THREEQ);

  logic [31:0] pend_inc;
  assign pend_inc = (pend_r == 32'hFFFF_FFFF) ? pend_r : pend_r + 32'd1;

  logic [PW-1:0] hoff, loff;
  assign loff = nl_r;
  assign hoff = (nh_r <= nl_r) ? nl_r + {{(PW-1){1'b0}}, 1'b1} : nh_r;

  assign sts.div_done     = (dcnt_r == IW'(PW));
  assign sts.renorm_emit  = emit0 || emit1;
  assign sts.renorm_stop  = !(emit0 || emit1 || quart);
  assign sts.renorm_limit = (rcnt_r == RW'(P));
  assign sts.eom          = eom_r;

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    pend_nxt = pend_r;
    if (cmd.load) begin
      high_nxt = hi_eff;
    end else if (cmd.narrow) begin
      if (valid_r) begin
        high_nxt = low_r + P'(hoff) - {{(P-1){1'b0}}, 1'b1};
        low_nxt  = low_r + P'(loff);
      end
    end else if (cmd.renorm) begin
      if (emit1) begin
        low_nxt  = low_r - HALF;
        high_nxt = high_r - HALF;
      end else if (quart) begin
        low_nxt  = low_r - QUART;
        high_nxt = high_r - QUART;
        pend_nxt = pend_inc;
      end
      if (emit0 || emit1) pend_nxt = '0;
      high_nxt = {high_nxt[P-2:0], 1'b1};
      low_nxt  = {low_nxt[P-2:0], 1'b0};
    end else if (cmd.flush) begin
      low_nxt  = '0;
      high_nxt = '1;
      pend_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '1;
      pend_r <= '0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r     <= in_total;
      eom_r   <= in_end_of_message;
      valid_r <= (in_total != '0) && (in_cum_high != '0) &&
                 (in_cum_low < in_cum_high) && (in_cum_high <= in_total);
      // dividend = range * count, quotient built in place
      nh_r    <= PW'(range_w) * PW'(in_cum_high);
      nl_r    <= PW'(range_w) * PW'(in_cum_low);
      rh_r    <= '0;
      rl_r    <= '0;
      dcnt_r  <= '0;
      rcnt_r  <= '0;
    end else if (cmd.div_step) begin
      if (th[CB+1]) begin
        rh_r <= CB'(0) + {rh_r[CB-1:0], nh_r[PW-1]};
        nh_r <= {nh_r[PW-2:0], 1'b0};
      end else begin
        rh_r <= th[CB:0];
        nh_r <= {nh_r[PW-2:0], 1'b1};
      end
      if (tl[CB+1]) begin
        rl_r <= CB'(0) + {rl_r[CB-1:0], nl_r[PW-1]};
        nl_r <= {nl_r[PW-2:0], 1'b0};
      end else begin
        rl_r <= tl[CB:0];
        nl_r <= {nl_r[PW-2:0], 1'b1};
      end
      dcnt_r <= dcnt_r + IW'(1);
    end else if (cmd.renorm) begin
      rcnt_r <= rcnt_r + RW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.renorm && (emit0 || emit1)) begin
      has_r  <= 1'b1;
      bit_r  <= emit1;
      fol_r  <= pend_r;
      last_r <= 1'b0;
      done_r <= 1'b0;
    end else if (cmd.flush) begin
      has_r  <= 1'b1;
      bit_r  <= low_r >= QUART;
      fol_r  <= pend_inc;
      last_r <= 1'b1;
      done_r <= 1'b1;
    end else if (cmd.marker) begin
      has_r  <= 1'b0;
      bit_r  <= 1'b0;
      fol_r  <= '0;
      last_r <= 1'b1;
      done_r <= 1'b0;
    end else if (cmd.mark_last) begin
      last_r <= 1'b1;
    end
  end

  assign res_has_bit = has_r;
  assign res_bit     = bit_r;
  assign res_follow  = fol_r;
  assign res_last    = last_r;
  assign res_done    = done_r;

endmodule

[hw/rtl/ace_ctrl.sv]
// Sequencing controller for the arithmetic encoder.
module ace_ctrl import ace_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ace_sts_t sts,
  output ace_cmd_t cmd
);

  ace_state_t state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       hold_r, hold_nxt;   // result register holds an unreleased bit

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      hold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      hold_r  <= hold_nxt;
    end
  end

  // a held result blocks anything that would overwrite it
  logic free;
  assign free = !ov_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    ov_nxt    = ov_r && out_stall;
    hold_nxt  = hold_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_NARROW;
        else cmd.div_step = 1'b1;
      end
      ST_NARROW: begin
        cmd.narrow = 1'b1;
        state_nxt  = ST_RENORM;
      end
      ST_RENORM: begin
        if (sts.renorm_stop || sts.renorm_limit) begin
          state_nxt = ST_FINAL;
        end else if (sts.renorm_emit) begin
          if (hold_r) begin
            // another bit follows: the hidden one is not last, release it
            ov_nxt   = 1'b1;
            hold_nxt = 1'b0;
          end else if (free) begin
            cmd.renorm = 1'b1;
            hold_nxt   = 1'b1;
          end
        end else begin
          cmd.renorm = 1'b1;
        end
      end
      ST_FINAL: begin
        if (hold_r) begin
          // last emitted bit; it ends the symbol unless a flush beat follows
          if (!sts.eom) begin
            cmd.mark_last = 1'b1;
            state_nxt     = ST_IDLE;
          end
          ov_nxt   = 1'b1;
          hold_nxt = 1'b0;
        end else if (free) begin
          if (sts.eom) cmd.flush = 1'b1;
          else cmd.marker = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;

endmodule

[sim/tb.sv]
// Testbench for the carry-free integer arithmetic encoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PREC = 32;
  localparam int CB   = 16;
  localparam logic [PREC-1:0] HALF_PT = 32'h8000_0000;
  localparam logic [PREC-1:0] QTR_PT  = 32'h4000_0000;
  localparam logic [PREC-1:0] TQ_PT   = 32'hC000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CB-1:0] in_cum_low = '0, in_cum_high = '0, in_total = '0;
  logic in_end_of_message = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_has_bit, out_out_bit, out_last_of_symbol, out_stream_done;
  logic [31:0] out_follow_count;

  typedef struct packed {
    logic has_bit;
    logic bit_val;
    logic [31:0] follow;
    logic last_sym;
    logic done;
  } code_beat_t;

  code_beat_t coded_q[$];
  int mismatches = 0;
  int rx_hold = 0;       // long receiver hold-off, in cycles
  bit long_hold_req = 1'b0;
  bit rx_idle_en = 1'b1;
  bit tx_idle_en = 1'b1;

  // predictor state
  logic [PREC-1:0] enc_lo, enc_hi;
  logic [31:0] enc_pend;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  arith_coder_encode #(.PRECISION(PREC), .COUNT_BITS(CB)) u_dut (.*);

  function automatic logic [63:0] scale_off(logic [63:0] a, logic [63:0] c, logic [63:0] t);
    return (a / t) * c + ((a % t) * c) / t;
  endfunction

  // Append one expected beat.
  task automatic queue_beat(code_beat_t b);
    coded_q = {coded_q, b};
  endtask

  // Narrow, renormalize and flush exactly as the encoder should; queue beats.
  task automatic predict_symbol(logic [CB-1:0] cl, logic [CB-1:0] ch,
                                logic [CB-1:0] tot, logic eom);
    logic [63:0] lo, hi, rng, hoff, loff;
    int steps;
    int emitted;
    code_beat_t b;
    lo = enc_lo; hi = enc_hi;
    steps = 0; emitted = 0;
    if (hi < lo) hi = lo;
    if (tot != 0 && ch != 0 && cl < ch && ch <= tot) begin
      rng  = hi - lo + 1;
      hoff = scale_off(rng, ch, tot);
      loff = scale_off(rng, cl, tot);
      if (hoff <= loff) hoff = loff + 1;
      hi = lo + hoff - 1;
      lo = lo + loff;
    end
    while (steps < PREC) begin
      if (hi < HALF_PT || lo >= HALF_PT) begin
        b = '{1'b1, lo >= HALF_PT, enc_pend, 1'b0, 1'b0};
        queue_beat(b);
        emitted++;
        enc_pend = '0;
        if (lo >= HALF_PT) begin
          hi -= HALF_PT;
          lo -= HALF_PT;
        end
      end else if (lo >= QTR_PT && hi < TQ_PT) begin
        if (enc_pend != 32'hFFFF_FFFF) enc_pend++;
        hi -= QTR_PT;
        lo -= QTR_PT;
      end else begin
        break;
      end
      hi = ((hi << 1) | 1) & 64'hFFFF_FFFF;
      lo = (lo << 1) & 64'hFFFF_FFFF;
      steps++;
    end
    enc_lo = lo[PREC-1:0];
    enc_hi = hi[PREC-1:0];
    if (eom) begin
      if (enc_pend != 32'hFFFF_FFFF) enc_pend++;
      b = '{1'b1, lo >= QTR_PT, enc_pend, 1'b1, 1'b1};
      queue_beat(b);
      enc_lo = '0; enc_hi = '1; enc_pend = '0;
    end else if (emitted == 0) begin
      b = '{1'b0, 1'b0, 32'd0, 1'b1, 1'b0};
      queue_beat(b);
    end else begin
      b = coded_q[coded_q.size() - 1];
      b.last_sym = 1'b1;
      coded_q[coded_q.size() - 1] = b;
    end
  endtask

  // Send one symbol beat, sometimes with a random idle burst ahead of it.
  task automatic send_symbol(logic [CB-1:0] cl, logic [CB-1:0] ch,
                             logic [CB-1:0] tot, logic eom);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cum_low <= cl; in_cum_high <= ch; in_total <= tot; in_end_of_message <= eom;
    predict_symbol(cl, ch, tot, eom);
    do @(posedge clk); while (in_stall);
  endtask

  // Random well-formed symbol.
  task automatic send_valid_symbol(logic eom);
    logic [CB-1:0] tot, cl, ch;
    case ($urandom_range(0, 3))
      0: tot = CB'($urandom_range(1, 4));
      1: tot = CB'($urandom_range(1, 255));
      2: tot = 16'hFFFF;
      default: tot = CB'($urandom_range(1, 65535));
    endcase
    ch = CB'($urandom_range(1, tot));
    cl = CB'($urandom_range(0, ch - 1));
    send_symbol(cl, ch, tot, eom);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    do @(posedge clk); while (coded_q.size() != 0);
  endtask

  // Results checker: compare each beat taken against the oldest expectation.
  always @(posedge clk) begin
    code_beat_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_has_bit, out_out_bit, out_follow_count, out_last_of_symbol,
              out_stream_done};
      if (coded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = coded_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("beat mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Receiver stall: long hold-off when requested, else random bursts while enabled.
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      out_stall <= 1'b1;
      rx_hold <= 600;
    end else if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else if (rx_idle_en && $urandom_range(0, 15) == 0) begin
      out_stall <= 1'b1;
      rx_hold <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_extremes();
    send_symbol(16'd0, 16'd1, 16'd1, 1'b0);          // whole interval
    send_symbol(16'd0, 16'd1, 16'hFFFF, 1'b0);       // narrowest bottom
    send_symbol(16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0); // narrowest top
    send_symbol(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0); // middle, quarter rule
    send_symbol(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_symbol(16'd1, 16'd3, 16'd4, 1'b1);
    drain_wait();
  endtask

  task automatic test_invalid_counts();
    send_symbol(16'd0, 16'd1, 16'd0, 1'b0);          // total zero
    send_symbol(16'd0, 16'd0, 16'd5, 1'b0);          // cum_high zero
    send_symbol(16'd3, 16'd3, 16'd5, 1'b0);          // empty symbol
    send_symbol(16'd4, 16'd2, 16'd5, 1'b0);          // reversed
    send_symbol(16'd1, 16'd9, 16'd5, 1'b1);          // cum_high above total
    send_symbol(16'd0, 16'd0, 16'd0, 1'b1);          // flush right after flush
    drain_wait();
  endtask

  task automatic test_pending_runs();
    // middle symbols keep the interval straddling the half: pending grows
    for (int i = 0; i < 8; i++) send_symbol(16'd32767, 16'd32769, 16'hFFFF, 1'b0);
    send_symbol(16'd0, 16'd1, 16'd2, 1'b0);
    send_symbol(16'd32767, 16'd32769, 16'hFFFF, 1'b1);
    drain_wait();
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_valid_symbol($urandom_range(0, 9) == 0);
    drain_wait();
    // sender pauses until every result is in
    for (int i = 0; i < 10; i++) begin
      send_valid_symbol(i == 9);
      drain_wait();
    end
  endtask

  task automatic test_random_messages();
    for (int i = 0; i < 300; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_symbol(CB'($urandom), CB'($urandom), CB'($urandom),
                    1'($urandom_range(0, 1)));
      end else begin
        send_valid_symbol($urandom_range(0, 11) == 0);
      end
      if (i == 250) begin
        drain_wait();
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
      end
    end
    send_valid_symbol(1'b1);
  endtask

  initial begin
    enc_lo = '0; enc_hi = '1; enc_pend = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_invalid_counts();
    test_pending_runs();
    test_backpressure();
    test_random_messages();
    drain_wait();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && coded_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
